// ===== src/assert_macros.svh =====
// Assertion macros used by the encoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property including reset cycles
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/fpcm_pkg.sv =====
// Package with formats, widths and conversion functions for the PCM encoder
`default_nettype none
package fpcm_pkg;
  localparam int unsigned InW = 32;
  localparam int unsigned OutW = 64;
  localparam int unsigned CntW = 4;
  localparam int unsigned FmtW = 3;

  localparam logic [FmtW-1:0] FMT_UNKNOWN = 3'd0;
  localparam logic [FmtW-1:0] FMT_U8 = 3'd1;
  localparam logic [FmtW-1:0] FMT_S16 = 3'd2;
  localparam logic [FmtW-1:0] FMT_S24 = 3'd3;
  localparam logic [FmtW-1:0] FMT_S32 = 3'd4;
  localparam logic [FmtW-1:0] FMT_F32 = 3'd5;
  localparam logic [FmtW-1:0] FMT_F64 = 3'd6;
  localparam logic [FmtW-1:0] FMT_RESET = FMT_S16;

  typedef struct packed {
    logic [OutW-1:0] packed_bytes;
    logic [CntW-1:0] byte_count;
  } result_t;

  // Clamp, scale by 2^k, round half away from zero, saturate (k <= 31)
  function automatic logic [32:0] scale_int(input logic [31:0] x, input logic [4:0] k);
    logic neg;
    logic [7:0] e;
    logic [23:0] sig;
    logic [32:0] full;
    logic [32:0] mag;
    logic signed [9:0] sh;
    logic [5:0] r;
    logic [56:0] wide;
    begin
      neg = x[31];
      e = x[30:23];
      full = 33'd1 << k;
      sig = (e == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
      sh = ((e == 8'd0) ? 10'sd1 : $signed({2'b00, e})) - 10'sd150 + $signed({5'd0, k});
      r = 6'(-sh);
      wide = '0;
      if (e >= 8'd127) begin
        mag = full;
      end else if (sh >= 0) begin
        wide = {33'd0, sig} << sh[5:0];
        mag = wide[32:0];
      end else if (-sh >= 10'sd26) begin
        mag = '0;
      end else begin
        wide = ({33'd0, sig} + (57'd1 << (r - 6'd1))) >> r;
        mag = wide[32:0];
      end
      if (neg) begin
        if (mag > full) mag = full;
        scale_int = -mag;
      end else begin
        if (mag > full - 33'd1) mag = full - 33'd1;
        scale_int = mag;
      end
    end
  endfunction

  // Priority encoder: index of the highest set bit of a 23-bit mantissa
  function automatic logic [4:0] top_bit(input logic [22:0] m);
    logic [4:0] p;
    begin
      p = '0;
      for (int i = 0; i < 23; i++) begin
        if (m[i]) p = 5'(i);
      end
      top_bit = p;
    end
  endfunction

  // Widen binary32 to binary64 exactly; a NaN comes out with its quiet bit set
  function automatic logic [63:0] widen(input logic [31:0] x);
    logic [7:0] e;
    logic [22:0] m;
    logic [4:0] p;
    logic [51:0] frac;
    logic [10:0] ex;
    begin
      e = x[30:23];
      m = x[22:0];
      p = top_bit(m);
      frac = {m, 29'd0};
      ex = 11'({3'd0, e} + 11'd896);
      if (e == 8'hFF) begin
        ex = 11'h7FF;
        if (m != '0) frac[51] = 1'b1;
      end else if (e == 8'd0) begin
        ex = 11'({6'd0, p} + 11'd874);
        frac = 52'({29'd0, m} << (6'd52 - {1'b0, p}));
        if (m == '0) begin
          ex = '0;
          frac = '0;
        end
      end
      widen = {x[31], ex, frac};
    end
  endfunction
endpackage
`default_nettype wire

// ===== src/fpcm_if.sv =====
// Valid/ready stream interface
`default_nettype none
interface fpcm_if #(parameter int unsigned W = 32) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/fpcm_conv.sv =====
// Combinational conversion of one sample into its encoded bytes
`default_nettype none
module fpcm_conv (
  input  wire logic [fpcm_pkg::FmtW-1:0] fmt,
  input  wire logic [fpcm_pkg::InW-1:0] sample_bits,
  output fpcm_pkg::result_t res
);
  import fpcm_pkg::*;
  logic nan;
  logic [32:0] s7, s15, s23, s31;

  assign nan = (sample_bits[30:23] == 8'hFF) && (sample_bits[22:0] != '0);

  // Scale for each integer width
  always_comb begin
    s7 = scale_int(sample_bits, 5'd7);
    s15 = scale_int(sample_bits, 5'd15);
    s23 = scale_int(sample_bits, 5'd23);
    s31 = scale_int(sample_bits, 5'd31);
  end

  // Select the encoding for the format
  always_comb begin
    res = '0;
    unique case (fmt)
      FMT_U8: begin
        res.packed_bytes = nan ? 64'd128 : {56'd0, s7[7:0] + 8'd128};
        res.byte_count = 4'd1;
      end
      FMT_S16: begin
        res.packed_bytes = nan ? '0 : {48'd0, s15[15:0]};
        res.byte_count = 4'd2;
      end
      FMT_S24: begin
        res.packed_bytes = nan ? '0 : {40'd0, s23[23:0]};
        res.byte_count = 4'd3;
      end
      FMT_S32: begin
        res.packed_bytes = nan ? '0 : {32'd0, s31[31:0]};
        res.byte_count = 4'd4;
      end
      FMT_F32: begin
        res.packed_bytes = {32'd0, sample_bits};
        res.byte_count = 4'd4;
      end
      FMT_F64: begin
        res.packed_bytes = widen(sample_bits);
        res.byte_count = 4'd8;
      end
      default: res = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/float_sample_to_pcm_encoder_top.sv =====
// Top level of the float sample to PCM encoder
//  channel | dir | payload
//  cfg     | in  | sample_format, 3 bits
//  in      | in  | sample_bits, 32 bits
//  out     | out | packed_bytes 64 bits, byte_count 4 bits
// One sample a cycle while out is ready: input register, one conversion stage, output register.
// An input beat passes through the input register and then the output register to the output.
// rst (synchronous) empties both registers and sets the format to s16.
// An output stall holds the result; the input stage advances into it when freed.
`default_nettype none
`include "assert_macros.svh"
module float_sample_to_pcm_encoder_top (
  input wire logic clk,
  input wire logic rst,
  fpcm_if.sink   cfg,
  fpcm_if.sink   in,
  fpcm_if.source out
);
  import fpcm_pkg::*;
  logic [FmtW-1:0] sample_format;
  logic s_valid;
  logic [InW-1:0] s_data;
  logic o_valid;
  result_t o_res, conv_res;
  logic o_free, s_free;

  assign cfg.ready = 1'b1;
  assign o_free = !o_valid || out.ready;
  assign s_free = !s_valid || o_free;
  assign in.ready = s_free;

  // Hold the format register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_RESET;
    end else if (cfg.valid) begin
      sample_format <= cfg.data[FmtW-1:0];
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_free) begin
      s_valid <= in.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (s_free && in.valid) s_data <= in.data;
  end

  fpcm_conv u_conv (.fmt(sample_format), .sample_bits(s_data), .res(conv_res));

  // Advance the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= s_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (o_free && s_valid) o_res <= conv_res;
  end

  assign out.valid = o_valid;
  assign out.data = {o_res.packed_bytes, o_res.byte_count};

  `ASSERT_CLK(a_hold, clk, rst, o_valid && !out.ready |=> o_valid && $stable(o_res), "result lost")
  `ASSERT_CLK(a_adv, clk, rst, s_valid && o_free |=> o_valid, "stage not advanced")
  `ASSERT_ALWAYS(a_rst, clk, rst |=> !o_valid && !s_valid, "reset not clearing")
endmodule
`default_nettype wire
